// ===== sv/ip_prefix_acl_first_match_macros.svh =====
// ---------------------------------------------------------------------------
// ip_prefix_acl_first_match macros
// Assertion macros, empty when built for synthesis.
// ---------------------------------------------------------------------------
`ifndef IP_PREFIX_ACL_FIRST_MATCH_MACROS_SVH
`define IP_PREFIX_ACL_FIRST_MATCH_MACROS_SVH

`ifndef SYNTHESIS
`define ACL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ACL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ACL_ASSERT(lbl, clk, rstn, prop, msg)
`define ACL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/ipacl_pkg.sv =====
// ---------------------------------------------------------------------------
// ipacl_pkg
// Shared types and constants of the first-match prefix access list.
// ---------------------------------------------------------------------------
package ipacl_pkg;

  localparam int unsigned RULE_DEPTH = 16;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned PLEN_W     = 6;

  typedef enum logic {
    KIND_ADD   = 1'b0,
    KIND_CHECK = 1'b1
  } kind_e;

  // token handed from cell to cell
  typedef struct packed {
    logic              vld;
    kind_e             kind;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] mask;
    logic              allow;
    logic              done;
    logic              res;
    logic              seen;
  } acl_tok_t;

endpackage

// ===== sv/ipacl_head.sv =====
// ---------------------------------------------------------------------------
// ipacl_head
// Entry stage: builds the prefix mask and launches a token into the chain.
// ---------------------------------------------------------------------------
module ipacl_head (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic                          kind_i,
  input  logic [ipacl_pkg::ADDR_W-1:0]  address_i,
  input  logic [ipacl_pkg::PLEN_W-1:0]  prefix_len_i,
  input  logic                          rule_allow_i,
  output ipacl_pkg::acl_tok_t           tok_o
);
  import ipacl_pkg::*;

  acl_tok_t          tok_d, tok_q;
  logic [ADDR_W-1:0] mask;

  assign mask = ~({ADDR_W{1'b1}} >> prefix_len_i);

  always_comb begin
    tok_d       = '0;
    tok_d.vld   = valid_i;
    tok_d.kind  = kind_e'(kind_i);
    tok_d.allow = rule_allow_i;
    tok_d.mask  = mask;
    unique case (kind_e'(kind_i))
      KIND_ADD: begin
        tok_d.addr = address_i & mask;
        // refuse an over-long prefix
        if (prefix_len_i > PLEN_W'(ADDR_W)) begin
          tok_d.done = 1'b1;
          tok_d.res  = 1'b0;
        end
      end
      KIND_CHECK: begin
        tok_d.addr = address_i;
      end
      default: tok_d.addr = address_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== sv/ipacl_cell.sv =====
// ---------------------------------------------------------------------------
// ipacl_cell
// One rule slot: stores a rule from a passing add, matches a passing check.
// ---------------------------------------------------------------------------
module ipacl_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  ipacl_pkg::acl_tok_t tok_i,
  output ipacl_pkg::acl_tok_t tok_o,
  output logic                occ_o
);
  import ipacl_pkg::*;

  acl_tok_t          tok_d, tok_q;
  logic              occ_q, occ_d;
  logic              wr;
  logic [ADDR_W-1:0] net_q, mask_q;
  logic              allow_q;

  always_comb begin
    tok_d = tok_i;
    occ_d = occ_q;
    wr    = 1'b0;
    if (tok_i.vld && !tok_i.done) begin
      unique case (tok_i.kind)
        KIND_ADD: begin
          if (!occ_q) begin
            wr         = 1'b1;
            occ_d      = 1'b1;
            tok_d.done = 1'b1;
            tok_d.res  = 1'b1;
          end
        end
        KIND_CHECK: begin
          if (occ_q) begin
            tok_d.seen = 1'b1;
            if ((tok_i.addr & mask_q) == net_q) begin
              tok_d.done = 1'b1;
              tok_d.res  = allow_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      occ_q <= 1'b0;
    end else if (adv_i) begin
      tok_q <= tok_d;
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && wr) begin
      net_q   <= tok_i.addr;
      mask_q  <= tok_i.mask;
      allow_q <= tok_i.allow;
    end
  end

  assign tok_o = tok_q;
  assign occ_o = occ_q;

endmodule

// ===== sv/ip_prefix_acl_first_match.sv =====
// ---------------------------------------------------------------------------
// ip_prefix_acl_first_match
// Ordered first-match IPv4 prefix access list built as a chain of rule cells.
// ---------------------------------------------------------------------------
// Every item, add or check, enters an entry stage and then walks a chain of
// RULE_DEPTH rule cells in insertion order, one cell per cycle while the chain
// is not stalled. A new item is taken in every cycle that no stalled result
// holds the chain, so the sustained rate is then one item per cycle.
// An add settles in the first free cell it passes; a check takes the mark
// of the first occupied cell that matches. Items keep their order, so a
// check always sees exactly the adds that came before it. A stalled result
// freezes the whole chain, and in_stall_o follows out_stall_i in that case.
module ip_prefix_acl_first_match (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [ipacl_pkg::ADDR_W-1:0]  address_i,
  input  logic [ipacl_pkg::PLEN_W-1:0]  prefix_len_i,
  input  logic                          rule_allow_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          permitted_o,
  output logic                          stored_o
);
  import ipacl_pkg::*;
  `include "ip_prefix_acl_first_match_macros.svh"

  acl_tok_t              tok [RULE_DEPTH+1];
  logic [RULE_DEPTH-1:0] occ_vec;
  logic                  adv;
  acl_tok_t              last;

  assign last = tok[RULE_DEPTH];
  assign adv  = !(last.vld && out_stall_i);

  ipacl_head u_head (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .valid_i      (in_valid_i),
    .kind_i       (kind_i),
    .address_i    (address_i),
    .prefix_len_i (prefix_len_i),
    .rule_allow_i (rule_allow_i),
    .tok_o        (tok[0])
  );

  for (genvar g = 0; g < RULE_DEPTH; g++) begin : g_cell
    ipacl_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1]),
      .occ_o  (occ_vec[g])
    );
  end

  assign in_stall_o  = !adv;
  assign out_valid_o = last.vld;

  always_comb begin
    permitted_o = 1'b0;
    stored_o    = 1'b0;
    unique case (last.kind)
      KIND_ADD:   stored_o    = last.done && last.res;
      KIND_CHECK: permitted_o = last.done ? last.res : !last.seen;
      default: ;
    endcase
  end

  `ACL_ASSERT(a_occ_prefix, clk_i, rst_ni,
    (((occ_vec >> 1) & ~occ_vec) == '0), "occupancy has a hole")
  `ACL_ASSERT(a_occ_hold, clk_i, rst_ni,
    (out_valid_o && out_stall_i) |=> $stable(occ_vec), "table changed while stalled")
  `ACL_ASSERT(a_occ_grow, clk_i, rst_ni,
    1'b1 |=> ($countones(occ_vec) <= $countones($past(occ_vec)) + 1),
    "more than one rule stored per cycle")
  `ACL_ASSERT_ALWAYS(a_occ_keep, clk_i,
    rst_ni |=> (!rst_ni || ($countones(occ_vec) >= $countones($past(occ_vec)))),
    "stored rule lost")

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-match IPv4 prefix access list. Rule adds
// and address lookups are sent in random bursts while the result side stalls
// on its own pattern. Each accepted add updates an in-bench copy of the
// ordered rule table, and each verdict is compared against it in order.
// ----------------------------------------------------------------------------
module tb_top;
  import ipacl_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = RULE_DEPTH + 8;

  typedef struct packed {
    kind_e             kind;
    logic [ADDR_W-1:0] addr;
    logic [PLEN_W-1:0] plen;
    logic              allow;
  } acl_item_t;

  typedef struct packed {
    logic permitted;
    logic stored;
  } verdict_t;

  typedef struct {
    logic [ADDR_W-1:0] net;
    int unsigned       plen;
  } rule_hint_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              kind_i       = 1'b0;
  logic [ADDR_W-1:0] address_i    = '0;
  logic [PLEN_W-1:0] prefix_len_i = '0;
  logic              rule_allow_i = 1'b0;
  logic              out_stall_i  = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic              permitted_o;
  logic              stored_o;

  logic [ADDR_W-1:0] model_net   [RULE_DEPTH];
  logic [ADDR_W-1:0] model_mask  [RULE_DEPTH];
  logic              model_allow [RULE_DEPTH];
  int unsigned       model_count = 0;

  verdict_t    verdict_q [$];
  rule_hint_t  added_rules [$];
  int unsigned rules_sent     = 0;
  int unsigned burst_left     = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned stall_tick     = 0;
  int unsigned stall_mode     = 0;
  acl_item_t   taken;
  verdict_t    want;

  ip_prefix_acl_first_match i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .address_i    (address_i),
    .prefix_len_i (prefix_len_i),
    .rule_allow_i (rule_allow_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .permitted_o  (permitted_o),
    .stored_o     (stored_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] prefix_mask(int unsigned len);
    return (len == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - len));
  endfunction

  function automatic verdict_t verdict_of(acl_item_t it);
    verdict_t          v;
    logic [ADDR_W-1:0] m;
    bit                hit;
    v   = '0;
    hit = 1'b0;
    if (it.kind == KIND_ADD) begin
      if (it.plen <= ADDR_W && model_count < RULE_DEPTH) begin
        m = prefix_mask(it.plen);
        model_net[model_count]   = it.addr & m;
        model_mask[model_count]  = m;
        model_allow[model_count] = it.allow;
        model_count++;
        v.stored = 1'b1;
      end
    end else if (model_count == 0) begin
      v.permitted = 1'b1;
    end else begin
      for (int unsigned i = 0; i < model_count; i++) begin
        if (!hit && (it.addr & model_mask[i]) == model_net[i]) begin
          v.permitted = model_allow[i];
          hit = 1'b1;
        end
      end
    end
    return v;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        taken = '{kind_e'(kind_i), address_i, prefix_len_i, rule_allow_i};
        verdict_q.push_back(verdict_of(taken));
      end
      if (out_valid_o && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result transfer with no item outstanding");
        end else begin
          want = verdict_q.pop_front();
          if (permitted_o !== want.permitted)
            report_mismatch($sformatf("permitted %b, want %b", permitted_o, want.permitted));
          if (stored_o !== want.stored)
            report_mismatch($sformatf("stored %b, want %b", stored_o, want.stored));
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_tick % 64 == 0)
      stall_mode = $urandom_range(0, 3);
    stall_tick++;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= ((stall_tick % 7) < 3);
    endcase
  end

  task automatic idle_gap(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic send_item(acl_item_t it);
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    kind_i       <= it.kind;
    address_i    <= it.addr;
    prefix_len_i <= it.plen;
    rule_allow_i <= it.allow;
    do @(posedge clk_i); while (in_stall_o);
    if (burst_left > 0)
      burst_left--;
    if (burst_left == 0) begin
      idle_gap(($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
    end
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic add_rule(logic [ADDR_W-1:0] a, int unsigned plen, logic allow);
    acl_item_t it;
    it.kind  = KIND_ADD;
    it.addr  = a;
    it.plen  = PLEN_W'(plen);
    it.allow = allow;
    if (plen <= ADDR_W) begin
      added_rules.push_back('{a, plen});
      rules_sent++;
    end
    send_item(it);
  endtask

  task automatic check_addr(logic [ADDR_W-1:0] a);
    acl_item_t it;
    it.kind  = KIND_CHECK;
    it.addr  = a;
    it.plen  = PLEN_W'($urandom);
    it.allow = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  function automatic logic [ADDR_W-1:0] pick_probe();
    int unsigned       sel;
    rule_hint_t        r;
    logic [ADDR_W-1:0] m;
    logic [ADDR_W-1:0] a;
    sel = $urandom_range(0, 9);
    if (sel == 9)
      return $urandom_range(0, 1) ? {ADDR_W{1'b1}} : {ADDR_W{1'b0}};
    if (added_rules.size() == 0 || sel >= 7)
      return $urandom;
    r = added_rules[$urandom_range(0, added_rules.size() - 1)];
    m = prefix_mask(r.plen);
    a = (r.net & m) | ($urandom & ~m);
    if (sel == 6 && r.plen != 0)
      a ^= ADDR_W'(1) << $urandom_range(ADDR_W - r.plen, ADDR_W - 1);
    return a;
  endfunction

  task automatic add_random_rule();
    add_rule($urandom, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 7) :
             $urandom_range(8, 32), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_empty_table();
    check_addr('0);
    check_addr('1);
  endtask

  task automatic test_prefix_limits();
    add_rule($urandom, 33, 1'b1);
    add_rule('1, 63, 1'b0);
    check_addr($urandom);
  endtask

  task automatic test_first_match_order();
    add_rule('1, 32, 1'b0);
    check_addr('1);
    check_addr(32'hFFFF_FFFE);
    add_rule(32'h0A00_0000, 8, 1'b1);
    check_addr(32'h0A01_0203);
    check_addr(32'h0B00_0000);
    add_rule(32'h0A01_0000, 16, 1'b0);
    check_addr(32'h0A01_0505);
    add_rule('1, 1, 1'b1);
    check_addr(32'hC000_0000);
    check_addr(32'h4000_0000);
  endtask

  task automatic test_random_mix(int unsigned n, bit hold_midway);
    int unsigned r;
    for (int unsigned k = 0; k < n; k++) begin
      if (hold_midway && k == n / 2)
        wait_for_results();
      r = $urandom_range(0, 29);
      if (r == 0 && (rules_sent < RULE_DEPTH - 1 || rules_sent >= RULE_DEPTH))
        add_random_rule();
      else if (r == 1)
        add_rule($urandom, $urandom_range(33, 63), 1'($urandom_range(0, 1)));
      else
        check_addr(pick_probe());
    end
  endtask

  task automatic test_full_table();
    while (rules_sent < RULE_DEPTH - 1)
      add_random_rule();
    add_rule($urandom, 0, 1'($urandom_range(0, 1)));
    add_rule('1, 32, 1'b1);
    add_rule($urandom, 0, 1'b0);
    repeat (6) check_addr(pick_probe());
    wait_for_results();
  endtask

  initial begin
    burst_left = $urandom_range(1, 16);
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_table();
    test_prefix_limits();
    test_first_match_order();
    test_random_mix(440, 1'b1);
    test_full_table();
    test_random_mix(240, 1'b0);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
